>>> rtl/oltbl_pkg.sv
// shared types and constants for the ordered list table engine
`timescale 1ns / 1ps
`default_nettype none
package oltbl_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   localparam logic signed [DATA_W-1:0] FAIL_DATA = '1;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_INSERT,
      S_DELETE,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/ordered_list_table_engine.sv
// ordered list of signed values kept as a dense table in one synchronous memory
//
//   channel   direction  ports
//   req_      in         req_valid, req_ready, req_cmd, req_position, req_value
//   rsp_      out        rsp_valid, rsp_ready, rsp_data, rsp_status, rsp_count, rsp_is_empty
//
// append and any rejected command go straight to the result, find does one memory read
// insert shifts the entries from the position up to the tail, delete searches the whole list:
// the shift and the search walk the memory one entry per cycle through its single read port
// reset empties the list at once; entries are not cleared
// a finished result waits in the rsp_ output register while the next transaction is taken
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_table_engine
   import oltbl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [2:0]                    rsp_status,
   output logic [COUNT_W-1:0]            rsp_count,
   output logic                          rsp_is_empty
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     found_ff, found_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   status_type               res_status_ff, res_status_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [2:0]               rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_is_empty_ff;

   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rsp_load;

   cmd_type                  cmd;
   logic                     req_fire;
   logic                     out_free;
   logic                     is_full;
   logic                     is_empty;
   logic [CNT_W-1:0]         pos_ext;
   logic                     ins_range;
   logic                     find_range;
   logic                     ins_last;
   logic                     del_last;
   logic                     del_match;

   assign cmd        = cmd_type'(req_cmd);
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign pos_ext    = CNT_W'(req_position);
   assign ins_range  = (req_position != '0) && (pos_ext >= count_ff);
   assign find_range = (pos_ext >= count_ff);
   // insert writes up to the old tail slot, delete reads up to the last entry
   assign ins_last   = (CNT_W'(idx_ff) == count_ff);
   assign del_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign del_match  = (rdata_ff == val_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_APPEND: state_in = S_DONE;
                  CMD_INSERT: state_in = (is_full || ins_range) ? S_DONE : S_INSERT;
                  CMD_DELETE: state_in = is_empty ? S_DONE : S_DELETE;
                  CMD_FIND:   state_in = (is_empty || find_range) ? S_DONE : S_FIND;
               endcase
            end
         end
         S_FIND:   state_in = S_DONE;
         S_INSERT: state_in = ins_last ? S_DONE : S_INSERT;
         S_DELETE: state_in = del_last ? S_DONE : S_DELETE;
         S_DONE:   state_in = out_free ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = carry_ff;
      rd_addr       = idx_ff + IDX_W'(1);
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      val_in        = val_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = (cmd == CMD_DELETE) ? '0 : IDX_W'(req_position);
            if (req_fire) begin
               val_in        = req_value;
               carry_in      = req_value;
               found_in      = 1'b0;
               idx_in        = (cmd == CMD_DELETE) ? '0 : IDX_W'(req_position);
               res_data_in   = '0;
               res_status_in = ST_OK;
               unique case (cmd)
                  CMD_APPEND: begin
                     if (is_full) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(count_ff);
                        mem_wdata = req_value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     priority if (is_full) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_FULL;
                     end else if (ins_range) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_RANGE;
                     end
                  end
                  CMD_DELETE: begin
                     if (is_empty) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_EMPTY;
                     end
                  end
                  CMD_FIND: begin
                     priority if (is_empty) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_EMPTY;
                     end else if (find_range) begin
                        res_data_in   = FAIL_DATA;
                        res_status_in = ST_RANGE;
                     end
                  end
               endcase
            end
         end
         S_FIND: begin
            res_data_in   = rdata_ff;
            res_status_in = ST_OK;
         end
         S_INSERT: begin
            // write the carried value, pick up the entry it displaces
            mem_we   = 1'b1;
            carry_in = rdata_ff;
            idx_in   = idx_ff + IDX_W'(1);
            if (ins_last) begin
               count_in      = count_ff + CNT_W'(1);
               res_data_in   = '0;
               res_status_in = ST_OK;
            end
         end
         S_DELETE: begin
            // once the match is passed, every entry moves down by one
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff - IDX_W'(1);
               mem_wdata = rdata_ff;
            end
            if (del_match) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (del_last) begin
               if (found_ff || del_match) begin
                  count_in      = count_ff - CNT_W'(1);
                  res_data_in   = '0;
                  res_status_in = ST_OK;
               end else begin
                  res_data_in   = FAIL_DATA;
                  res_status_in = ST_NOTFOUND;
               end
            end
         end
         S_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      carry_ff      <= carry_in;
      val_ff        <= val_in;
      found_ff      <= found_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff     <= res_data_ff;
         rsp_status_ff   <= res_status_ff;
         rsp_count_ff    <= COUNT_W'(count_ff);
         rsp_is_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

endmodule
`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the ordered list table engine
`timescale 1ns / 1ps
module tb;
   import oltbl_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_type;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } list_result_type;

   class list_scoreboard;
      logic signed [DATA_W-1:0] entries [DEPTH];
      int unsigned              fill;
      list_result_type          awaited_results [$];
      int                       errors;
      int                       commands;
      int                       checked;
      int                       status_hits [5];

      // mirror the list update for one transaction and queue its result
      function void take_command(cmd_type cmd, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
         list_result_type res;
         int              hit;
         res.data   = FAIL_DATA;
         res.status = ST_OK;
         hit        = -1;
         commands++;
         case (cmd)
            CMD_APPEND: begin
               if (fill == DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  entries[fill] = val;
                  fill++;
                  res.data = '0;
               end
            end
            CMD_INSERT: begin
               if (fill == DEPTH) begin
                  res.status = ST_FULL;
               end else if (pos != 0 && pos >= fill) begin
                  res.status = ST_RANGE;
               end else begin
                  for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
                  entries[pos] = val;
                  fill++;
                  res.data = '0;
               end
            end
            CMD_DELETE: begin
               if (fill == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  for (int i = 0; i < fill; i++) begin
                     if (entries[i] == val) begin
                        hit = i;
                        break;
                     end
                  end
                  if (hit < 0) begin
                     res.status = ST_NOTFOUND;
                  end else begin
                     for (int i = hit; i + 1 < fill; i++) entries[i] = entries[i+1];
                     fill--;
                     res.data = '0;
                  end
               end
            end
            default: begin
               if (fill == 0) begin
                  res.status = ST_EMPTY;
               end else if (pos >= fill) begin
                  res.status = ST_RANGE;
               end else begin
                  res.data = entries[pos];
               end
            end
         endcase
         res.count    = COUNT_W'(fill);
         res.is_empty = (fill == 0);
         awaited_results.push_back(res);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] data, logic [2:0] status,
                                 logic [COUNT_W-1:0] count, logic is_empty);
         list_result_type exp;
         if (awaited_results.size() == 0) begin
            $display("%0t: result with nothing awaited: data %0d status %0d count %0d",
                     $time, data, status, count);
            errors++;
            return;
         end
         exp = awaited_results.pop_front();
         checked++;
         status_hits[exp.status]++;
         if (data !== exp.data) begin
            $display("%0t: data expected %0d actual %0d", $time, exp.data, data);
            errors++;
         end
         if (status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
            errors++;
         end
         if (count !== exp.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp.count, count);
            errors++;
         end
         if (is_empty !== exp.is_empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $time, exp.is_empty, is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_cmd;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_data;
   logic [2:0]               rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;

   bit             steady;
   bit             hold_off;
   int             cycles;
   list_scoreboard sb = new();

   ordered_list_table_engine i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d results outstanding",
                  CYCLE_LIMIT, sb.awaited_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data, rsp_status, rsp_count, rsp_is_empty);
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
      end
   end

   task automatic send_command(input cmd_type cmd, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
      sb.take_command(cmd, pos, val);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      // small values give duplicates so delete has to pick the first match
      if (roll < 40) return $urandom_range(0, 7);
      if (roll < 50) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      mix_type                  mix;
      cmd_type                  cmd;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      int                       roll;

      mix          = MIX_EVEN;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_APPEND;
      req_position <= '0;
      req_value    <= '0;
      reset        <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list corners, extremes, full list, shifts
      send_command(CMD_FIND,   4'd0,  32'sd5);
      send_command(CMD_DELETE, 4'd0,  32'sd5);
      send_command(CMD_INSERT, 4'd3,  32'sd9);
      send_command(CMD_INSERT, 4'd0,  32'sh8000_0000);
      send_command(CMD_DELETE, 4'd0,  32'sh8000_0000);
      send_command(CMD_INSERT, 4'd0,  32'sh7fff_ffff);
      for (int i = 1; i <= 13; i++) send_command(CMD_APPEND, 4'd15, -i);
      send_command(CMD_INSERT, 4'd15, 32'sd100);
      send_command(CMD_INSERT, 4'd13, 32'sh5555_aaaa);
      send_command(CMD_APPEND, 4'd0,  32'sh8000_0000);
      send_command(CMD_APPEND, 4'd0,  32'sd1);
      send_command(CMD_INSERT, 4'd15, 32'sd2);
      send_command(CMD_FIND,   4'd15, 32'sd0);
      send_command(CMD_DELETE, 4'd0,  32'sd12345);
      send_command(CMD_DELETE, 4'd0,  32'sh7fff_ffff);
      send_command(CMD_FIND,   4'd15, 32'sd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 900 && n < 1200);
         if (n == 500) hold_off = 1'b1;
         if (n % 64 == 0) mix = mix_type'($urandom_range(0, 2));
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_GROW:
               cmd = roll < 35 ? CMD_APPEND : roll < 70 ? CMD_INSERT :
                     roll < 85 ? CMD_DELETE : CMD_FIND;
            MIX_SHRINK:
               cmd = roll < 10 ? CMD_APPEND : roll < 20 ? CMD_INSERT :
                     roll < 80 ? CMD_DELETE : CMD_FIND;
            default:
               cmd = cmd_type'($urandom_range(0, 3));
         endcase
         if (sb.fill > 0 && $urandom_range(0, 99) < 60)
            pos = POS_W'($urandom_range(0, sb.fill - 1));
         else
            pos = POS_W'($urandom_range(0, 15));
         if (cmd == CMD_DELETE && sb.fill > 0 && $urandom_range(0, 99) < 70)
            val = sb.entries[$urandom_range(0, sb.fill - 1)];
         else
            val = pick_value();
         send_command(cmd, pos, val);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d results checked, including a %0d cycle output stall",
               sb.commands, sb.checked, HOLD_CYCLES);
      $display("results by status: ok %0d, empty %0d, range %0d, not found %0d, full %0d",
               sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_RANGE],
               sb.status_hits[ST_NOTFOUND], sb.status_hits[ST_FULL]);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
